>>> design/tga_rle_pkg.sv
// Shared types and constants of the TGA RLE pixel decoder.
package tga_rle_pkg;

    // Widths fixed by the stream format
    localparam int BYTE_W      = 8;
    localparam int PIXEL_W     = 32;
    localparam int COUNT_W     = 8;
    localparam int BPP_W       = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Default for the pixel byte limit of the top level
    localparam int MAX_PIXEL_BYTES_DEFAULT = 4;

    // Packet header decoding
    localparam logic [BYTE_W-1:0] RUN_HEADER_MIN = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_HEADER_BIAS = 8'd127;

    // Register reset values
    localparam logic [BPP_W-1:0]      BPP_RESET   = 3'd4;
    localparam logic [CFG_DATA_W-1:0] IMAGE_RESET = 32'd1;

    // Depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BYTES_PER_PIXEL = 2'd0,
        CFG_IMAGE_PIXELS    = 2'd1
    } t_cfg_index;

    // Packet parser state
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RAW    = 2'd1,
        PH_RUN    = 2'd2
    } t_phase;

    // One finished pixel as handed from the parser to the output stage
    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic [COUNT_W-1:0] count;     // requested repeat count
        logic [COUNT_W-1:0] left;      // pixels left in the image (exact when done)
        logic               done;      // this pixel completes the image
        logic               more;      // raw packet still had pixels to come
    } t_token;

endpackage

>>> design/tga_rle_if.sv
// Stream and configuration channel interfaces of the TGA RLE decoder.
interface tga_rle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface tga_rle_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        overrun_error;

    modport source (output valid, output pixel_value, output repeat_count,
                    output image_done, output overrun_error, input ready);
    modport sink (input valid, input pixel_value, input repeat_count,
                  input image_done, input overrun_error, output ready);
endinterface

interface tga_rle_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> design/tga_rle_front.sv
// Packet parser: decodes headers, gathers pixel bytes and counts pixels per image.
module tga_rle_front #(
    parameter int MAX_PIXEL_BYTES = tga_rle_pkg::MAX_PIXEL_BYTES_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [tga_rle_pkg::BPP_W-1:0]       i_bpp,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  i_image_pixels,
    input  logic                                i_valid,
    input  logic [tga_rle_pkg::BYTE_W-1:0]      i_byte,
    output logic                                o_ready,
    input  logic                                i_full,
    output logic                                o_push,
    output tga_rle_pkg::t_token                 o_token
);
    import tga_rle_pkg::*;

    localparam int AsmW = 8 * MAX_PIXEL_BYTES;
    localparam int PosW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    t_phase               r_phase, n_phase;
    logic [COUNT_W-1:0]   r_remain, n_remain;
    logic [COUNT_W-1:0]   r_run, n_run;
    logic [PosW-1:0]      r_bpos, n_bpos;
    logic [AsmW-1:0]      r_asm, n_asm;
    logic [PIXEL_W-1:0]   r_done_cnt, n_done_cnt;

    logic                 accept;
    logic [BPP_W-1:0]     eff_bpp;
    logic [AsmW-1:0]      asm_cur;
    logic                 last_byte;
    logic [PIXEL_W-1:0]   img;
    logic [PIXEL_W-1:0]   left;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   more;
    logic                 done;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Clamp bytes per pixel into one to the lane count
    always_comb begin
        eff_bpp = (i_bpp == '0) ? BPP_W'(1) : i_bpp;
        if (eff_bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
            eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
        end
    end

    // Merge the incoming byte into its lane
    always_comb begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            asm_cur[8*k +: 8] = r_asm[8*k +: 8] | ((r_bpos == PosW'(k)) ? i_byte : 8'h00);
        end
    end

    assign last_byte = ((4'(r_bpos) + 4'd1) >= 4'(eff_bpp));

    // Pixels left in the image and the repeat request of this pixel
    always_comb begin
        img   = (i_image_pixels == '0) ? PIXEL_W'(1) : i_image_pixels;
        left  = (r_done_cnt < img) ? (img - r_done_cnt) : PIXEL_W'(1);
        count = COUNT_W'(1);
        more  = '0;
        if (r_phase == PH_RUN) begin
            count = (r_run == '0) ? COUNT_W'(1) : r_run;
        end else if (r_remain != '0) begin
            more = r_remain - COUNT_W'(1);
        end
        done = ({{(PIXEL_W-COUNT_W){1'b0}}, count} >= left);
    end

    // Token for the output stage
    always_comb begin
        o_token.value = PIXEL_W'(asm_cur);
        o_token.count = count;
        o_token.left  = left[COUNT_W-1:0];
        o_token.done  = done;
        o_token.more  = (more != '0);
    end

    // Next state of the packet parser
    always_comb begin
        n_phase    = r_phase;
        n_remain   = r_remain;
        n_run      = r_run;
        n_bpos     = r_bpos;
        n_asm      = r_asm;
        n_done_cnt = r_done_cnt;
        o_push     = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_RAW, PH_RUN: begin
                    if (!last_byte) begin
                        n_asm  = asm_cur;
                        n_bpos = r_bpos + PosW'(1);
                    end else begin
                        o_push = 1'b1;
                        n_asm  = '0;
                        n_bpos = '0;
                        if (done || more == '0) begin
                            n_phase  = PH_HEADER;
                            n_remain = '0;
                            n_run    = '0;
                        end else begin
                            n_remain = more;
                        end
                        n_done_cnt = done ? '0
                                   : r_done_cnt + {{(PIXEL_W-COUNT_W){1'b0}}, count};
                    end
                end
                default: begin
                    // Header byte: open a raw or a run packet
                    if (i_byte < RUN_HEADER_MIN) begin
                        n_phase  = PH_RAW;
                        n_remain = i_byte + COUNT_W'(1);
                        n_run    = '0;
                    end else begin
                        n_phase  = PH_RUN;
                        n_run    = i_byte - RUN_HEADER_BIAS;
                        n_remain = COUNT_W'(1);
                    end
                    n_bpos = '0;
                    n_asm  = '0;
                end
            endcase
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_remain   <= '0;
            r_run      <= '0;
            r_bpos     <= '0;
            r_asm      <= '0;
            r_done_cnt <= '0;
        end else begin
            r_phase    <= n_phase;
            r_remain   <= n_remain;
            r_run      <= n_run;
            r_bpos     <= n_bpos;
            r_asm      <= n_asm;
            r_done_cnt <= n_done_cnt;
        end
    end

endmodule

>>> design/tga_rle_queue.sv
// Short token queue between the packet parser and the output stage.
module tga_rle_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tga_rle_pkg::t_token i_token,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output tga_rle_pkg::t_token o_token
);
    import tga_rle_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_token          r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store an entry on push
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_token;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

>>> design/tga_rle_back.sv
// Output stage: clips the repeat count, sets the overrun flag and holds the result.
module tga_rle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  tga_rle_pkg::t_token i_token,
    output logic                o_pop,
    tga_rle_pix_if.source       o_pix
);
    import tga_rle_pkg::*;

    logic               r_valid;
    logic [PIXEL_W-1:0] r_value;
    logic [COUNT_W-1:0] r_count;
    logic               r_done;
    logic               r_over;
    logic               load;

    assign load  = i_valid && (!r_valid || o_pix.ready);
    assign o_pop = load;

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Clip at the image end and hold the result
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= i_token.value;
            r_done  <= i_token.done;
            if (i_token.done) begin
                r_count <= i_token.left;
                r_over  <= (i_token.count > i_token.left) || i_token.more;
            end else begin
                r_count <= i_token.count;
                r_over  <= 1'b0;
            end
        end
    end

    assign o_pix.valid         = r_valid;
    assign o_pix.pixel_value   = r_value;
    assign o_pix.repeat_count  = r_count;
    assign o_pix.image_done    = r_done;
    assign o_pix.overrun_error = r_over;

endmodule

>>> design/tga_rle_pixel_decoder_unit.sv
// TGA RLE pixel decoder: one compressed byte in per cycle, one pixel result out per pixel.
// Takes one stream byte per clock cycle without gaps as long as the result side keeps up;
// a result passes through the queue and then the output register. Header and pixel-byte
// parsing, pixel counting and the image-end check are combinational in the parser, and a
// two-entry queue plus the output register let the byte side run on while a result waits.
// Bytes per pixel (register 0) and image size (register 1) are written through the
// configuration channel, which is always ready; change them only while the decoder is idle.
// No clearing pass follows reset.
module tga_rle_pixel_decoder_unit #(
    parameter int MAX_PIXEL_BYTES = tga_rle_pkg::MAX_PIXEL_BYTES_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tga_rle_cfg_if.sink   i_cfg,
    tga_rle_byte_if.sink  i_byte,
    tga_rle_pix_if.source o_pix
);
    import tga_rle_pkg::*;

    logic [BPP_W-1:0]      r_bpp;
    logic [CFG_DATA_W-1:0] r_image_pixels;
    logic                  push, full, pop, q_valid;
    t_token                push_token, q_token;

    assign i_cfg.ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp          <= BPP_RESET;
            r_image_pixels <= IMAGE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_BYTES_PER_PIXEL: r_bpp          <= i_cfg.wr_data[BPP_W-1:0];
                CFG_IMAGE_PIXELS:    r_image_pixels <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    tga_rle_front #(
        .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bpp          (r_bpp),
        .i_image_pixels (r_image_pixels),
        .i_valid        (i_byte.valid),
        .i_byte         (i_byte.in_byte),
        .o_ready        (i_byte.ready),
        .i_full         (full),
        .o_push         (push),
        .o_token        (push_token)
    );

    tga_rle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_token),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_token (q_token)
    );

    tga_rle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_token (q_token),
        .o_pop   (pop),
        .o_pix   (o_pix)
    );

endmodule

>>> design/tga_rle_checker.sv
// Port-level checks of the TGA RLE decoder and their binding to the top level.
module tga_rle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_repeat_count,
    input logic        i_image_done,
    input logic        i_overrun_error
);

    // Synchronous reset empties the output register
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A waiting result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // Repeat count stays within one to one hundred twenty-eight
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_repeat_count != 8'd0) && (i_repeat_count <= 8'd128))
        else $error("repeat count out of range");

    // An overrun always ends the image
    a_overrun_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overrun_error |-> i_image_done)
        else $error("overrun without image end");

endmodule

bind tga_rle_pixel_decoder_unit tga_rle_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_pix.valid),
    .i_out_ready     (o_pix.ready),
    .i_repeat_count  (o_pix.repeat_count),
    .i_image_done    (o_pix.image_done),
    .i_overrun_error (o_pix.overrun_error)
);
